@@ design/diff_drive_odometry_with_slip_top_assert.svh @@
// Assertion macros included by the odometry top module.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef DIFF_DRIVE_ODOMETRY_WITH_SLIP_TOP_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_WITH_SLIP_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDO_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDO_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ddo_pkg.sv @@
// Shared types, constants and the arctangent table of the odometry block.
// Used by the multiplier, the CORDIC and the top module; depends on nothing.
`timescale 1ns / 1ps

package ddo_pkg;

    localparam int MUL_BW       = 31;
    localparam int MUL_LEN_BITS = 5;
    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_BITS    = 32;

    localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;
    localparam logic signed [TRIG_BITS-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [16:0] SLIP_ONE = 17'sd16384;

    localparam logic REG_WHEEL_BASE   = 1'b0;
    localparam logic REG_WHEEL_RADIUS = 1'b1;

    localparam logic [15:0] WHEEL_BASE_RST   = 16'd10486;
    localparam logic [15:0] WHEEL_RADIUS_RST = 16'd2163;

    typedef struct packed {
        logic                    start;
        logic [MUL_LEN_BITS-1:0] len;
    } t_mul_ctl;

    function automatic logic signed [TRIG_BITS:0] atan_val(input logic [4:0] idx);
        logic signed [TRIG_BITS:0] v;
        case (idx)
            5'd0:  v = 33'sd536870912;
            5'd1:  v = 33'sd316933406;
            5'd2:  v = 33'sd167458907;
            5'd3:  v = 33'sd85004756;
            5'd4:  v = 33'sd42667331;
            5'd5:  v = 33'sd21354465;
            5'd6:  v = 33'sd10679838;
            5'd7:  v = 33'sd5340245;
            5'd8:  v = 33'sd2670163;
            5'd9:  v = 33'sd1335087;
            5'd10: v = 33'sd667544;
            5'd11: v = 33'sd333772;
            5'd12: v = 33'sd166886;
            5'd13: v = 33'sd83443;
            5'd14: v = 33'sd41722;
            5'd15: v = 33'sd20861;
            5'd16: v = 33'sd10430;
            5'd17: v = 33'sd5215;
            5'd18: v = 33'sd2608;
            5'd19: v = 33'sd1304;
            5'd20: v = 33'sd652;
            5'd21: v = 33'sd326;
            5'd22: v = 33'sd163;
            5'd23: v = 33'sd81;
            5'd24: v = 33'sd41;
            5'd25: v = 33'sd20;
            5'd26: v = 33'sd10;
            5'd27: v = 33'sd5;
            5'd28: v = 33'sd3;
            5'd29: v = 33'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

@@ design/ddo_mul.sv @@
// Bit-serial unsigned shift-add multiplier, multiplier bits taken MSB first.
// Depends on ddo_pkg for the control struct.
`timescale 1ns / 1ps

module ddo_mul #(
    parameter int AW = 48
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ddo_pkg::t_mul_ctl                     i_ctl,
    input  logic [AW-1:0]                         i_a,
    input  logic [ddo_pkg::MUL_BW-1:0]            i_b,
    output logic                                  o_busy,
    output logic                                  o_done,
    output logic [AW+ddo_pkg::MUL_BW-1:0]         o_prod
);

    localparam int PW = AW + ddo_pkg::MUL_BW;

    logic [PW-1:0]                      r_acc;
    logic [AW-1:0]                      r_a;
    logic [ddo_pkg::MUL_BW-1:0]         r_b;
    logic [ddo_pkg::MUL_LEN_BITS-1:0]   r_cnt;
    logic                               r_busy;
    logic                               r_done;
    logic [PW-1:0]                      n_acc;

    always_comb begin
        n_acc = {r_acc[PW-2:0], 1'b0} + (r_b[ddo_pkg::MUL_BW-1] ? PW'(r_a) : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.len;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ddo_pkg::MUL_LEN_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[ddo_pkg::MUL_BW-2:0], 1'b0};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

@@ design/ddo_div.sv @@
// Bit-serial restoring divider by a 16-bit divisor, one quotient bit a cycle.
// Stand-alone; uses no package items.
`timescale 1ns / 1ps

module ddo_div #(
    parameter int NW = 35
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [15:0]   i_den,
    output logic          o_busy,
    output logic [NW-1:0] o_quot
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [15:0]   r_rem;
    logic [15:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [16:0]   trial;
    logic          qbit;

    always_comb begin
        trial = {r_rem, r_q[NW-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= {r_q[NW-2:0], qbit};
            r_rem <= qbit ? 16'(trial - {1'b0, r_den}) : trial[15:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

@@ design/ddo_cordic.sv @@
// Iterative rotation-mode CORDIC giving cosine and sine of a binary angle in Q30.
// Depends on ddo_pkg for the gain, the step count and the arctangent table.
`timescale 1ns / 1ps

module ddo_cordic #(
    parameter int AB = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic [AB-1:0]                          i_angle,
    output logic                                   o_busy,
    output logic signed [ddo_pkg::TRIG_BITS-1:0]   o_cos,
    output logic signed [ddo_pkg::TRIG_BITS-1:0]   o_sin
);

    localparam int TB = ddo_pkg::TRIG_BITS;
    localparam logic signed [TB:0] QUARTER = 33'sd1073741824;
    localparam logic signed [TB:0] HALF    = 33'sd2147483648;

    logic signed [TB-1:0] r_x;
    logic signed [TB-1:0] r_y;
    logic signed [TB:0]   r_z;
    logic                 r_flip;
    logic [4:0]           r_i;
    logic                 r_busy;
    logic [TB-1:0]        z_raw;
    logic signed [TB:0]   z_ext;
    logic signed [TB:0]   z_fold;
    logic                 flip;

    always_comb begin
        z_raw  = TB'(i_angle) << (TB - AB);
        z_ext  = (TB+1)'($signed(z_raw));
        z_fold = z_ext;
        flip   = 1'b0;
        if (z_ext > QUARTER) begin
            z_fold = z_ext - HALF;
            flip   = 1'b1;
        end else if (z_ext < -QUARTER) begin
            z_fold = z_ext + HALF;
            flip   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_i    <= '0;
        end else if (r_busy) begin
            r_i <= r_i + 1'b1;
            if (r_i == 5'(ddo_pkg::CORDIC_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= ddo_pkg::CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= z_fold;
            r_flip <= flip;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - (r_y >>> r_i);
                r_y <= r_y + (r_x >>> r_i);
                r_z <= r_z - ddo_pkg::atan_val(r_i);
            end else begin
                r_x <= r_x + (r_y >>> r_i);
                r_y <= r_y - (r_x >>> r_i);
                r_z <= r_z + ddo_pkg::atan_val(r_i);
            end
        end
    end

    assign o_busy = r_busy;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;

endmodule

@@ design/diff_drive_odometry_with_slip_top.sv @@
// An accepted input word yields its pose word after seven products run in turn
// through the one bit-serial multiplier; the divider and CORDIC run alongside it.
// A new word is taken only once the pose is written, so one word is in work at a time,
// and write-back waits while the previous pose word is unread.
// Reset (synchronous, active low) zeroes pose, heading and stored wheel angles
// and loads the default wheel base and radius.
`timescale 1ns / 1ps

module diff_drive_odometry_with_slip_top #(
    parameter int ANGLE_BITS    = 16,
    parameter int POSITION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // left_angle[15:0], right_angle[31:16], left_slip[47:32], right_slip[63:48]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pose_x[31:0], pose_y[63:32], pose_heading[79:64]
    output logic [79:0] m_axis_tdata
);

    localparam int A    = ANGLE_BITS;
    localparam int P    = POSITION_BITS;
    localparam int SW   = A + 16;
    localparam int SUMW = A + 17;
    localparam int MAW  = A + 32;
    localparam int PW   = MAW + ddo_pkg::MUL_BW;
    localparam int DNW  = A + 19;
    localparam int TB   = ddo_pkg::TRIG_BITS;
    localparam logic [PW:0] FWD_HALF = (PW+1)'(1) << (A + 42);
    localparam logic signed [52:0] DXY_HALF = 53'sd536870912;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ML   = 4'd1;
    localparam logic [3:0] S_MR   = 4'd2;
    localparam logic [3:0] S_SUM  = 4'd3;
    localparam logic [3:0] S_MSR  = 4'd4;
    localparam logic [3:0] S_MDR  = 4'd5;
    localparam logic [3:0] S_MT   = 4'd6;
    localparam logic [3:0] S_MC   = 4'd7;
    localparam logic [3:0] S_MS   = 4'd8;
    localparam logic [3:0] S_WB   = 4'd9;

    logic [3:0]             r_state;
    logic [15:0]            r_base;
    logic [15:0]            r_radius;
    logic [A-1:0]           r_left_st;
    logic [A-1:0]           r_right_st;
    logic [A-1:0]           r_heading;
    logic [P-1:0]           r_pos_x;
    logic [P-1:0]           r_pos_y;
    logic [A-1:0]           r_dr_mag;
    logic [15:0]            r_fr_mag;
    logic                   r_sr_neg;
    logic                   r_sl_neg;
    logic signed [SW-1:0]   r_sl;
    logic signed [SUMW-1:0] r_sum;
    logic signed [SUMW-1:0] r_dif;
    logic [MAW-1:0]         r_sumr;
    logic                   r_fwd_neg;
    logic [20:0]            r_fwd_mag;
    logic signed [22:0]     r_dx;
    logic signed [22:0]     r_dy;
    logic                   r_out_valid;
    logic [79:0]            r_out_data;

    logic                   in_acc;
    logic [A-1:0]           left_new;
    logic [A-1:0]           right_new;
    logic signed [A-1:0]    dl;
    logic signed [A-1:0]    dr;
    logic signed [16:0]     fl;
    logic signed [16:0]     fr;
    logic [A-1:0]           dl_mag;
    logic [A-1:0]           dr_mag;
    logic [15:0]            fl_mag;
    logic [15:0]            fr_mag;
    logic signed [SW-1:0]   sr_val;
    logic [SUMW-2:0]        sum_mag;
    logic [SUMW-2:0]        dif_mag;
    logic [15:0]            base_eff;
    logic [A+32:0]          div_x;
    logic [PW:0]            fwd_t;
    logic [20:0]            fwd_mag;
    logic [TB-2:0]          cos_mag;
    logic [TB-2:0]          sin_mag;
    logic                   trig_neg;
    logic [51:0]            p52;
    logic signed [52:0]     p_s;
    logic signed [52:0]     p_r;
    logic                   wb_go;

    ddo_pkg::t_mul_ctl              mul_ctl;
    logic [MAW-1:0]                 mul_a;
    logic [ddo_pkg::MUL_BW-1:0]     mul_b;
    logic                           mul_busy;
    logic                           mul_done;
    logic [PW-1:0]                  mul_prod;
    logic                           div_start;
    logic                           div_busy;
    logic [DNW-1:0]                 div_quot;
    logic                           cor_busy;
    logic signed [TB-1:0]           cor_cos;
    logic signed [TB-1:0]           cor_sin;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        left_new  = A'(s_axis_tdata[15:0]);
        right_new = A'(s_axis_tdata[31:16]);
        dl        = $signed(A'(left_new - r_left_st));
        dr        = $signed(A'(right_new - r_right_st));
        fl        = ddo_pkg::SLIP_ONE - 17'($signed(s_axis_tdata[47:32]));
        fr        = ddo_pkg::SLIP_ONE - 17'($signed(s_axis_tdata[63:48]));
        dl_mag    = dl[A-1] ? A'(-dl) : A'(dl);
        dr_mag    = dr[A-1] ? A'(-dr) : A'(dr);
        fl_mag    = fl[16] ? 16'(-fl) : fl[15:0];
        fr_mag    = fr[16] ? 16'(-fr) : fr[15:0];
        sr_val    = r_sr_neg ? -$signed(SW'(mul_prod)) : $signed(SW'(mul_prod));
        sum_mag   = r_sum[SUMW-1] ? (SUMW-1)'(-r_sum) : (SUMW-1)'(r_sum);
        dif_mag   = r_dif[SUMW-1] ? (SUMW-1)'(-r_dif) : (SUMW-1)'(r_dif);
        base_eff  = (r_base == 16'd0) ? 16'd1 : r_base;
        div_x     = (A+33)'(mul_prod[MAW-1:0]) + (A+33)'({base_eff, 13'b0});
        fwd_t     = (PW+1)'(mul_prod) + FWD_HALF;
        fwd_mag   = fwd_t[PW:A+43];
        cos_mag   = cor_cos[TB-1] ? (TB-1)'(-cor_cos) : (TB-1)'(cor_cos);
        sin_mag   = cor_sin[TB-1] ? (TB-1)'(-cor_sin) : (TB-1)'(cor_sin);
        trig_neg  = (r_state == S_MS) ? cor_sin[TB-1] : cor_cos[TB-1];
        p52       = mul_prod[51:0];
        p_s       = (r_fwd_neg ^ trig_neg) ? -$signed({1'b0, p52}) : $signed({1'b0, p52});
        p_r       = p_s + DXY_HALF;
        wb_go     = (r_state == S_WB) && !div_busy && (!r_out_valid || m_axis_tready);
    end

    always_comb begin
        mul_ctl   = '0;
        mul_a     = '0;
        mul_b     = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                mul_ctl.start = in_acc;
                mul_ctl.len   = 5'd16;
                mul_a         = MAW'(dl_mag);
                mul_b         = {fl_mag, {(ddo_pkg::MUL_BW-16){1'b0}}};
            end
            S_ML: begin
                mul_ctl.start = mul_done;
                mul_ctl.len   = 5'd16;
                mul_a         = MAW'(r_dr_mag);
                mul_b         = {r_fr_mag, {(ddo_pkg::MUL_BW-16){1'b0}}};
            end
            S_SUM: begin
                mul_ctl.start = 1'b1;
                mul_ctl.len   = 5'd16;
                mul_a         = MAW'(sum_mag);
                mul_b         = {r_radius, {(ddo_pkg::MUL_BW-16){1'b0}}};
            end
            S_MSR: begin
                mul_ctl.start = mul_done;
                mul_ctl.len   = 5'd16;
                mul_a         = MAW'(dif_mag);
                mul_b         = {r_radius, {(ddo_pkg::MUL_BW-16){1'b0}}};
            end
            S_MDR: begin
                mul_ctl.start = mul_done;
                mul_ctl.len   = 5'(ddo_pkg::MUL_BW);
                mul_a         = r_sumr;
                mul_b         = ddo_pkg::TWO_PI_Q28;
                div_start     = mul_done;
            end
            S_MT: begin
                mul_ctl.start = mul_done;
                mul_ctl.len   = 5'(ddo_pkg::MUL_BW);
                mul_a         = MAW'(fwd_mag);
                mul_b         = cos_mag;
            end
            S_MC: begin
                mul_ctl.start = mul_done;
                mul_ctl.len   = 5'(ddo_pkg::MUL_BW);
                mul_a         = MAW'(r_fwd_mag);
                mul_b         = sin_mag;
            end
            default: begin
                mul_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_base      <= ddo_pkg::WHEEL_BASE_RST;
            r_radius    <= ddo_pkg::WHEEL_RADIUS_RST;
            r_left_st   <= '0;
            r_right_st  <= '0;
            r_heading   <= '0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ddo_pkg::REG_WHEEL_BASE:   r_base   <= i_cfg_data;
                    ddo_pkg::REG_WHEEL_RADIUS: r_radius <= i_cfg_data;
                    default:                   r_base   <= r_base;
                endcase
            end
            if (m_axis_tready && !wb_go) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_left_st  <= left_new;
                        r_right_st <= right_new;
                        r_state    <= S_ML;
                    end
                end
                S_ML:  if (mul_done) r_state <= S_MR;
                S_MR:  if (mul_done) r_state <= S_SUM;
                S_SUM: r_state <= S_MSR;
                S_MSR: if (mul_done) r_state <= S_MDR;
                S_MDR: if (mul_done) r_state <= S_MT;
                S_MT:  if (mul_done) r_state <= S_MC;
                S_MC:  if (mul_done) r_state <= S_MS;
                S_MS:  if (mul_done) r_state <= S_WB;
                S_WB: begin
                    if (wb_go) begin
                        r_pos_x   <= r_pos_x + P'(r_dx);
                        r_pos_y   <= r_pos_y + P'(r_dy);
                        r_heading <= r_dif[SUMW-1] ? r_heading - div_quot[A-1:0]
                                                   : r_heading + div_quot[A-1:0];
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dr_mag <= dr_mag;
            r_fr_mag <= fr_mag;
            r_sl_neg <= dl[A-1] ^ fl[16];
            r_sr_neg <= dr[A-1] ^ fr[16];
        end
        if (r_state == S_ML && mul_done) begin
            r_sl <= r_sl_neg ? -$signed(SW'(mul_prod)) : $signed(SW'(mul_prod));
        end
        if (r_state == S_MR && mul_done) begin
            r_sum <= SUMW'(sr_val) + SUMW'(r_sl);
            r_dif <= SUMW'(sr_val) - SUMW'(r_sl);
        end
        if (r_state == S_MSR && mul_done) begin
            r_sumr    <= mul_prod[MAW-1:0];
            r_fwd_neg <= r_sum[SUMW-1];
        end
        if (r_state == S_MT && mul_done) begin
            r_fwd_mag <= fwd_mag;
        end
        if (r_state == S_MC && mul_done) begin
            r_dx <= p_r[52:30];
        end
        if (r_state == S_MS && mul_done) begin
            r_dy <= p_r[52:30];
        end
        if (wb_go) begin
            r_out_data[31:0]  <= 32'(r_pos_x + P'(r_dx));
            r_out_data[63:32] <= 32'(r_pos_y + P'(r_dy));
            r_out_data[79:64] <= 16'(r_dif[SUMW-1] ? r_heading - div_quot[A-1:0]
                                                   : r_heading + div_quot[A-1:0]);
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    ddo_mul #(
        .AW(MAW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mul_ctl),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_busy  (mul_busy),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    ddo_div #(
        .NW(DNW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_x[A+32:14]),
        .i_den   (base_eff),
        .o_busy  (div_busy),
        .o_quot  (div_quot)
    );

    ddo_cordic #(
        .AB(A)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (in_acc),
        .i_angle (r_heading),
        .o_busy  (cor_busy),
        .o_cos   (cor_cos),
        .o_sin   (cor_sin)
    );

`include "diff_drive_odometry_with_slip_top_assert.svh"

    `DDO_ASSERT_SAME(a_trig_ready, (r_state == S_MT) && mul_done, !cor_busy, "CORDIC still busy when cosine is needed")
    `DDO_ASSERT_SAME(a_mul_idle_on_start, mul_ctl.start, !mul_busy, "multiplier started while busy")
    `DDO_ASSERT_NEXT(a_heading_hold, r_state != S_WB, $stable(r_heading), "heading changed outside write-back")
    `DDO_ASSERT_NEXT(a_accept_starts, in_acc, (r_state == S_ML) && mul_busy, "accepted word did not start the multiplier")

endmodule
